// ----- hdl/npa_pkg.sv -----
// ----------------------------------------------------------------------------
// npa_pkg: shared types and constants for the node pool allocator
// Pool geometry, request codes and the request/response transaction structs.
// ----------------------------------------------------------------------------
package npa_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 1024;
    localparam int ADDR_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int FREE_W    = 12;
    localparam int HANDLE_W  = 10;
    localparam int FAIL_W    = 32;

    localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_SIZE);
    localparam logic [FREE_W-1:0] POOL_FREE = FREE_W'(POOL_SIZE);
    localparam logic [FAIL_W-1:0] FAIL_MAX  = '1;

    // Request kinds
    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] handle_in;
    } t_req;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] handle_out;
        logic [FREE_W-1:0]   free_count;
        logic [FAIL_W-1:0]   failed_allocs;
        logic [FAIL_W-1:0]   failed_frees;
    } t_rsp;

endpackage

// ----- hdl/npa_free_stack.sv -----
// ----------------------------------------------------------------------------
// npa_free_stack: storage for the LIFO free-handle stack
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module npa_free_stack (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [npa_pkg::ADDR_W-1:0]        i_wr_addr,
    input  logic [npa_pkg::HANDLE_W-1:0]      i_wr_data,
    input  logic                              i_rd_en,
    input  logic [npa_pkg::ADDR_W-1:0]        i_rd_addr,
    output logic [npa_pkg::HANDLE_W-1:0]      o_rd_data
);

    logic [npa_pkg::HANDLE_W-1:0] r_mem [npa_pkg::POOL_SIZE];
    logic [npa_pkg::HANDLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/node_pool_allocator_top.sv -----
// ----------------------------------------------------------------------------
// node_pool_allocator_top: free-list pool allocator with a bump pointer
// Hands out node handles from a LIFO free stack, else from a bump counter.
// ----------------------------------------------------------------------------
// An accepted request passes through the execute flag r_busy, then r_done drives o_done.
// A new request is refused while busy is high; the free stack's registered
//   read plus the read-modify-write step on the counts sets this.
// The receiver cannot stall: each response is shown for exactly one cycle.
// Reset (synchronous, active low) empties the stack, rewinds the bump count
//   and clears both failure counters; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module node_pool_allocator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  npa_pkg::t_req i_req,
    output logic          o_done,
    output npa_pkg::t_rsp o_rsp
);

    // Execute flag: high in the cycle after a transaction is accepted
    logic                           r_busy;
    logic                           r_done;
    npa_pkg::t_req                  r_req;
    npa_pkg::t_rsp                  r_rsp;
    npa_pkg::t_rsp                  n_rsp;

    // Pool state
    logic [npa_pkg::CNT_W-1:0]      r_stack_count;
    logic [npa_pkg::CNT_W-1:0]      n_stack_count;
    logic [npa_pkg::CNT_W-1:0]      r_bump_count;
    logic [npa_pkg::CNT_W-1:0]      n_bump_count;
    logic [npa_pkg::FAIL_W-1:0]     r_fail_alloc;
    logic [npa_pkg::FAIL_W-1:0]     n_fail_alloc;
    logic [npa_pkg::FAIL_W-1:0]     r_fail_free;
    logic [npa_pkg::FAIL_W-1:0]     n_fail_free;

    logic                           accept;
    logic                           stk_wr_en;
    logic [npa_pkg::ADDR_W-1:0]     stk_rd_addr;
    logic [npa_pkg::HANDLE_W-1:0]   stk_rd_data;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Read the top of stack at accept; the data lands for the execute cycle.
    // An empty stack reads a don't-care entry that is then ignored.
    assign stk_rd_addr = npa_pkg::ADDR_W'(r_stack_count - npa_pkg::CNT_W'(1));

    npa_free_stack u_free_stack (
        .i_clk     (i_clk),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (r_stack_count[npa_pkg::ADDR_W-1:0]),
        .i_wr_data (r_req.handle_in),
        .i_rd_en   (accept),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

    // Execute: decide the request, update counts, write back a freed handle.
    always_comb begin
        n_stack_count = r_stack_count;
        n_bump_count  = r_bump_count;
        n_fail_alloc  = r_fail_alloc;
        n_fail_free   = r_fail_free;
        stk_wr_en     = 1'b0;
        n_rsp         = '0;

        unique case (r_req.op)
            npa_pkg::OP_ALLOC: begin
                if (r_stack_count != '0) begin
                    // Pop the most recently freed handle
                    n_stack_count    = r_stack_count - npa_pkg::CNT_W'(1);
                    n_rsp.handle_out = stk_rd_data;
                end else if (r_bump_count >= npa_pkg::POOL_CNT) begin
                    // Pool exhausted
                    n_rsp.status = 1'b1;
                    if (r_fail_alloc != npa_pkg::FAIL_MAX) begin
                        n_fail_alloc = r_fail_alloc + npa_pkg::FAIL_W'(1);
                    end
                end else begin
                    // Hand out the next never-used handle
                    n_rsp.handle_out = npa_pkg::HANDLE_W'(r_bump_count);
                    n_bump_count     = r_bump_count + npa_pkg::CNT_W'(1);
                end
            end
            npa_pkg::OP_FREE: begin
                if (r_stack_count < npa_pkg::POOL_CNT) begin
                    stk_wr_en     = r_busy;
                    n_stack_count = r_stack_count + npa_pkg::CNT_W'(1);
                end else begin
                    // Stack full: drop the handle
                    n_rsp.status = 1'b1;
                    if (r_fail_free != npa_pkg::FAIL_MAX) begin
                        n_fail_free = r_fail_free + npa_pkg::FAIL_W'(1);
                    end
                end
            end
            npa_pkg::OP_FREE_ALL: begin
                n_stack_count = '0;
                n_bump_count  = '0;
                n_fail_alloc  = '0;
                n_fail_free   = '0;
            end
            npa_pkg::OP_NOP: begin
                // Report counts unchanged
            end
            default: begin
            end
        endcase

        n_rsp.free_count    = npa_pkg::POOL_FREE - npa_pkg::FREE_W'(n_bump_count)
                              + npa_pkg::FREE_W'(n_stack_count);
        n_rsp.failed_allocs = n_fail_alloc;
        n_rsp.failed_frees  = n_fail_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_done        <= 1'b0;
            r_stack_count <= '0;
            r_bump_count  <= '0;
            r_fail_alloc  <= '0;
            r_fail_free   <= '0;
        end else begin
            // Advance: accept -> execute -> response strobe
            r_busy <= accept;
            r_done <= r_busy;
            if (r_busy) begin
                r_stack_count <= n_stack_count;
                r_bump_count  <= n_bump_count;
                r_fail_alloc  <= n_fail_alloc;
                r_fail_free   <= n_fail_free;
            end
        end
    end

    // Payload registers: capture the request at accept, the response at execute
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("accepted transaction did not enter execute");

    a_exec_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_done && !r_busy))
        else $error("execute did not produce exactly one response");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stack_count <= npa_pkg::POOL_CNT) && (r_bump_count <= npa_pkg::POOL_CNT))
        else $error("stack or bump count beyond pool size");

    a_fail_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_rsp.status) |-> (r_rsp.handle_out == '0))
        else $error("failed transaction returned a handle");

    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(r_busy) |-> ($stable(r_stack_count) && $stable(r_bump_count)))
        else $error("pool counts changed outside execute");

endmodule
